[rtl/core/brvi_pkg.sv]
// Package for the band ratio vegetation index block.
// Holds register indexes, widths and the pipeline cell payload type. No dependencies.
package brvi_pkg;
    localparam int RAD_W  = 40;
    localparam int REF_W  = 40;
    localparam int QB     = 17;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_GAIN1  = 3'd0;
    localparam logic [IDX_W-1:0] REG_BIAS1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN2  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIAS2  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SCALE1 = 3'd4;
    localparam logic [IDX_W-1:0] REG_SCALE2 = 3'd5;
    localparam logic [IDX_W-1:0] REG_QA     = 3'd6;

    // One divider cell's item: partial remainder, quotient so far and flags.
    typedef struct packed {
        logic             vld;
        logic             ok;
        logic             neg;
        logic [REF_W:0]   den2;
        logic [REF_W+1:0] rem;
        logic [QB-1:0]    quo;
    } t_div;
endpackage

[rtl/core/brvi_div_cell.sv]
// One restoring division cell: produces one quotient bit per cycle while i_en is high.
// Depends on brvi_pkg.
module brvi_div_cell
    import brvi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);
    t_div r_d;
    t_div n_d;
    logic [REF_W+2:0] w_sh;
    logic [REF_W+2:0] w_sub;

    always_comb begin
        n_d   = i_d;
        w_sh  = {i_d.rem, 1'b0};
        w_sub = w_sh - {2'b00, i_d.den2};
        if (!w_sub[REF_W+2]) begin
            n_d.rem = w_sub[REF_W+1:0];
            n_d.quo = {i_d.quo[QB-2:0], 1'b1};
        end else begin
            n_d.rem = w_sh[REF_W+1:0];
            n_d.quo = {i_d.quo[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

[rtl/core/band_ratio_vegetation_index_top.sv]
// Pipeline: 5 front stages, then 16 divider cells, then 1 output register.
// Throughput: one item per clock while not stalled; the 16-cell restoring divider chain sets most of the latency.
// The whole pipeline advances when the output register is empty or being taken.
// Reset: synchronous, active low; clears the valid bits and the configuration registers.
// Top level of the band ratio vegetation index block; uses brvi_pkg and brvi_div_cell.
module band_ratio_vegetation_index_top
    import brvi_pkg::*;
#(
    parameter int DN_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_dn_first,
    input  logic [15:0]          i_dn_second,
    input  logic [15:0]          i_qa_word,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_index_value,
    output logic                 o_index_valid
);
    logic [23:0] r_gain1, r_bias1, r_gain2, r_bias2;
    logic [31:0] r_scale1, r_scale2;
    logic [15:0] r_qa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain1 <= '0; r_bias1 <= '0; r_gain2 <= '0; r_bias2 <= '0;
            r_scale1 <= '0; r_scale2 <= '0; r_qa <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN1:  r_gain1  <= i_cfg_data[23:0];
                REG_BIAS1:  r_bias1  <= i_cfg_data[23:0];
                REG_GAIN2:  r_gain2  <= i_cfg_data[23:0];
                REG_BIAS2:  r_bias2  <= i_cfg_data[23:0];
                REG_SCALE1: r_scale1 <= i_cfg_data;
                REG_SCALE2: r_scale2 <= i_cfg_data;
                REG_QA:     r_qa     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_ov;
    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    // Stage 1: dn * gain.
    logic              r_v1, r_qok1;
    logic [39:0]       r_p1a, r_p1b;
    // Stage 2: add bias, clamp.
    logic              r_v2, r_qok2;
    logic [RAD_W-1:0]  r_rad2a, r_rad2b;
    // Stage 3: two 20x32 partial products per band.
    logic              r_v3, r_qok3;
    logic [51:0]       r_hia, r_loa, r_hib, r_lob;
    // Stage 4: reflectance.
    logic              r_v4, r_qok4;
    logic [REF_W-1:0]  r_ra, r_rb;
    // Stage 5: sum and difference.
    logic              r_v5, r_qok5, r_neg5;
    logic [REF_W:0]    r_den5;
    logic [REF_W-1:0]  r_mag5;

    logic [DN_BITS-1:0] w_dna, w_dnb;
    logic signed [41:0] w_ra, w_rb;
    logic [52:0]        w_reflsa, w_reflsb;

    assign w_dna = i_dn_first[DN_BITS-1:0];
    assign w_dnb = i_dn_second[DN_BITS-1:0];
    assign w_ra  = $signed({2'b00, r_p1a}) + 42'(signed'(r_bias1));
    assign w_rb  = $signed({2'b00, r_p1b}) + 42'(signed'(r_bias2));
    assign w_reflsa = {13'd0, r_hia[51:12]} + 53'(({r_hia[11:0], 20'd0} + {12'd0, r_loa}) >> 32);
    assign w_reflsb = {13'd0, r_hib[51:12]} + 53'(({r_hib[11:0], 20'd0} + {12'd0, r_lob}) >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qok1  <= (i_qa_word == r_qa);
            r_p1a   <= 40'(w_dna) * 40'(r_gain1);
            r_p1b   <= 40'(w_dnb) * 40'(r_gain2);
            r_qok2  <= r_qok1;
            r_rad2a <= w_ra[41] ? '0 : w_ra[RAD_W-1:0];
            r_rad2b <= w_rb[41] ? '0 : w_rb[RAD_W-1:0];
            r_qok3  <= r_qok2;
            r_hia   <= 52'(r_rad2a[39:20]) * 52'(r_scale1);
            r_loa   <= 52'(r_rad2a[19:0]) * 52'(r_scale1);
            r_hib   <= 52'(r_rad2b[39:20]) * 52'(r_scale2);
            r_lob   <= 52'(r_rad2b[19:0]) * 52'(r_scale2);
            r_qok4  <= r_qok3;
            r_ra    <= w_reflsa[REF_W-1:0];
            r_rb    <= w_reflsb[REF_W-1:0];
            r_qok5  <= r_qok4;
            r_neg5  <= r_ra > r_rb;
            r_den5  <= {1'b0, r_ra} + {1'b0, r_rb};
            r_mag5  <= (r_ra > r_rb) ? r_ra - r_rb : r_rb - r_ra;
        end
    end

    // Since mag never exceeds den, the integer quotient bit is settled here and
    // the remainder starts below den; the cells then add the 16 fraction bits.
    t_div w_chain [0:QB-1];
    logic w_ge;
    assign w_ge = ({1'b0, r_mag5} >= r_den5);
    always_comb begin
        w_chain[0].vld  = r_v5;
        w_chain[0].ok   = r_qok5 && (r_den5 != '0);
        w_chain[0].neg  = r_neg5;
        w_chain[0].den2 = r_den5;
        w_chain[0].rem  = w_ge ? {1'b0, {1'b0, r_mag5} - r_den5} : {2'b00, r_mag5};
        w_chain[0].quo  = {{(QB-1){1'b0}}, w_ge};
    end

    genvar g;
    generate
        for (g = 0; g < QB-1; g++) begin : g_div
            brvi_div_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_d    (w_chain[g]),
                .o_d    (w_chain[g+1])
            );
        end
    endgenerate

    // quo = floor(mag*2^16/den); rounded half-up result is (quo+1)>>1.
    t_div         w_last;
    logic [QB:0]  w_qr;
    logic [15:0]  w_mag;
    logic [15:0]  w_val;
    assign w_last = w_chain[QB-1];
    assign w_qr   = ({1'b0, w_last.quo} + 18'd1) >> 1;
    always_comb begin
        w_mag = (w_qr > 18'd32767) ? 16'd32767 : w_qr[15:0];
        if (w_last.neg) begin
            w_val = (w_qr >= 18'd32768) ? 16'h8000 : 16'(-w_qr[15:0]);
        end else begin
            w_val = w_mag;
        end
    end

    logic signed [15:0] r_oval;
    logic               r_ook;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_oval <= '0;
            r_ook  <= 1'b0;
        end else if (w_en) begin
            r_ov   <= w_last.vld;
            r_oval <= w_last.ok ? w_val : 16'sd0;
            r_ook  <= w_last.ok;
        end
    end

    assign o_valid       = r_ov;
    assign o_index_value = r_oval;
    assign o_index_valid = r_ook;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_index_value)))
        else $error("output item changed while stalled");
    a_masked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_index_valid) |-> (o_index_value == 16'sd0))
        else $error("masked item carries a nonzero value");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid) |-> o_ready)
        else $error("input stalled with empty output register");
endmodule
